// ===== rtl/ctgb_pkg.sv =====
`default_nettype none

package ctgb_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam int CMD_W  = 3;
   localparam int CHAR_W = 8;
   localparam int KIND_W = 3;
   localparam int LEN_W  = 7;

   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RIGHT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_LEFT   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd4;

   localparam logic [KIND_W-1:0] KIND_DONE    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FULL    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CHAR    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;     // latch the request and issue its store read
      logic finish;     // complete an edit (or an empty dump) and load its result
      logic dump_step;  // emit the character held in the read register
   } ctgb_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic text_empty;
      logic dump_last;
      logic out_free;
   } ctgb_status_type;

endpackage

`default_nettype wire

// ===== rtl/ctgb_ctrl.sv =====
`default_nettype none

module ctgb_ctrl
   import ctgb_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [CMD_W-1:0] req_cmd,
   output logic                  req_stall,
   input  wire ctgb_status_type  status,
   output ctgb_cmd_type          cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FINISH,
      ST_DUMP
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.accept    = 1'b0;
      cmd.finish    = 1'b0;
      cmd.dump_step = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               // A dump of an empty buffer is answered like an edit.
               if (req_cmd == CMD_DUMP && !status.text_empty) begin
                  state_in = ST_DUMP;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_DUMP: begin
            if (status.out_free) begin
               cmd.dump_step = 1'b1;
               if (status.dump_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/ctgb_datapath.sv =====
`default_nettype none

module ctgb_datapath
   import ctgb_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire logic [CHAR_W-1:0] req_char_in,
   input  wire ctgb_cmd_type      cmd,
   output ctgb_status_type        status,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [KIND_W-1:0]      rsp_kind,
   output logic [CHAR_W-1:0]      rsp_char_out,
   output logic                   rsp_last,
   output logic [LEN_W-1:0]       rsp_text_length,
   output logic [LEN_W-1:0]       rsp_cursor_pos
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

   logic [CHAR_W-1:0] text_store_ff [DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   logic [CNT_W-1:0]  left_ff, left_in;
   logic [CNT_W-1:0]  right_ff, right_in;
   logic [CNT_W-1:0]  idx_ff;
   logic [CMD_W-1:0]  cmd_ff;
   logic [CHAR_W-1:0] char_ff;

   logic              rsp_valid_ff;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [CHAR_W-1:0] char_out_ff, char_out_in;
   logic              last_ff, last_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;

   logic [CNT_W-1:0]  total;
   logic [CNT_W-1:0]  idx_next;
   logic              dump_last;
   logic              out_free;
   logic              load;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     acc_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [CHAR_W-1:0] wr_data;

   // Store address of text position i: the left stack from the bottom, then
   // the right stack, which ends at the top entry.
   function automatic logic [AW-1:0] text_addr(input logic [CNT_W-1:0] i,
                                               input logic [CNT_W-1:0] left,
                                               input logic [CNT_W-1:0] tot);
      logic [CNT_W:0] a;
      begin
         if (i < left) begin
            a = {1'b0, i};
         end else begin
            a = {1'b0, i} + (CNT_W + 1)'(DEPTH) - {1'b0, tot};
         end
         return a[AW-1:0];
      end
   endfunction

   assign total     = left_ff + right_ff;
   assign idx_next  = idx_ff + 1'b1;
   assign dump_last = (idx_next == total);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign status.text_empty = (total == '0);
   assign status.dump_last  = dump_last;
   assign status.out_free   = out_free;

   always_comb begin
      unique case (req_cmd)
         CMD_RIGHT: acc_addr = (right_ff == '0) ? '0 : AW'(DEPTH_C - right_ff);
         CMD_LEFT:  acc_addr = (left_ff == '0) ? '0 : AW'(left_ff - 1'b1);
         CMD_DUMP:  acc_addr = text_addr('0, left_ff, total);
         default:   acc_addr = '0;
      endcase
   end

   assign rd_en   = cmd.accept || (cmd.dump_step && !dump_last);
   assign rd_addr = cmd.accept ? acc_addr : text_addr(idx_next, left_ff, total);

   always_comb begin
      wr_en       = 1'b0;
      wr_addr     = AW'(left_ff);
      wr_data     = char_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      load        = 1'b0;
      kind_in     = KIND_DONE;
      char_out_in = '0;
      last_in     = 1'b1;
      len_in      = '0;
      pos_in      = '0;
      if (cmd.finish) begin
         load = 1'b1;
         unique case (cmd_ff)
            CMD_INSERT: begin
               if (total == DEPTH_C) begin
                  kind_in = KIND_FULL;
               end else begin
                  wr_en   = 1'b1;
                  left_in = left_ff + 1'b1;
               end
            end
            CMD_DELETE: begin
               if (left_ff == '0) begin
                  kind_in = KIND_IGNORED;
               end else begin
                  left_in = left_ff - 1'b1;
               end
            end
            CMD_RIGHT: begin
               if (right_ff == '0) begin
                  kind_in = KIND_IGNORED;
               end else begin
                  wr_en    = 1'b1;
                  wr_data  = rd_data_ff;
                  left_in  = left_ff + 1'b1;
                  right_in = right_ff - 1'b1;
               end
            end
            CMD_LEFT: begin
               if (left_ff == '0) begin
                  kind_in = KIND_IGNORED;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = AW'(DEPTH_C - 1'b1 - right_ff);
                  wr_data  = rd_data_ff;
                  left_in  = left_ff - 1'b1;
                  right_in = right_ff + 1'b1;
               end
            end
            CMD_DUMP: begin
               kind_in = KIND_EMPTY;
            end
            default: begin
               kind_in = KIND_IGNORED;
            end
         endcase
         len_in = LEN_W'(left_in) + LEN_W'(right_in);
         pos_in = LEN_W'(left_in);
      end else if (cmd.dump_step) begin
         load        = 1'b1;
         kind_in     = KIND_CHAR;
         char_out_in = rd_data_ff;
         last_in     = dump_last;
         if (dump_last) begin
            left_in  = '0;
            right_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         text_store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= text_store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         right_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         left_ff  <= left_in;
         right_ff <= right_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff  <= req_cmd;
         char_ff <= req_char_in;
         idx_ff  <= '0;
      end else if (cmd.dump_step && !dump_last) begin
         idx_ff <= idx_next;
      end
      if (load) begin
         kind_ff     <= kind_in;
         char_out_ff <= char_out_in;
         last_ff     <= last_in;
         len_ff      <= len_in;
         pos_ff      <= pos_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_char_out    = char_out_ff;
   assign rsp_last        = last_ff;
   assign rsp_text_length = len_ff;
   assign rsp_cursor_pos  = pos_ff;

endmodule

`default_nettype wire

// ===== rtl/cursor_text_gap_buffer.sv =====
// Gap-buffer line editor with a cursor over a DEPTH-byte text store.
// Edit commands: the store read is issued as the transaction is accepted, and
// the write and result follow in the finish state once the output is free.
// A dump of N characters gives one result per cycle while the output is free,
// using the single store read port; the next request is taken after the last one.
// Synchronous active-high reset empties the text; store contents stay undefined.
`default_nettype none

module cursor_text_gap_buffer
   import ctgb_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire logic [CHAR_W-1:0] req_char_in,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [KIND_W-1:0]      rsp_kind,
   output logic [CHAR_W-1:0]      rsp_char_out,
   output logic                   rsp_last,
   output logic [LEN_W-1:0]       rsp_text_length,
   output logic [LEN_W-1:0]       rsp_cursor_pos
);

   ctgb_cmd_type    cmd;
   ctgb_status_type status;

   ctgb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ctgb_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_cmd),
      .req_char_in     (req_char_in),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_char_out    (rsp_char_out),
      .rsp_last        (rsp_last),
      .rsp_text_length (rsp_text_length),
      .rsp_cursor_pos  (rsp_cursor_pos)
   );

endmodule

`default_nettype wire

// ===== test/line_edit_checker.sv =====
`default_nettype none

module line_edit_checker
   import ctgb_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire logic [CHAR_W-1:0] req_char_in,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic [KIND_W-1:0] rsp_kind,
   input  wire logic [CHAR_W-1:0] rsp_char_out,
   input  wire logic              rsp_last,
   input  wire logic [LEN_W-1:0]  rsp_text_length,
   input  wire logic [LEN_W-1:0]  rsp_cursor_pos,
   output int                     mismatches,
   output int                     pending_results,
   output int                     commands_seen,
   output int                     results_seen,
   output int                     full_rejects,
   output int                     edge_ignores,
   output int                     dumped_chars
);

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CHAR_W-1:0] ch;
      logic              is_last;
      logic [LEN_W-1:0]  length;
      logic [LEN_W-1:0]  cursor;
   } line_result_type;

   logic [CHAR_W-1:0] text_mem [DEPTH];
   int unsigned       left_n;
   int unsigned       right_n;
   line_result_type   due_results [$];

   initial begin
      mismatches      = 0;
      pending_results = 0;
      commands_seen   = 0;
      results_seen    = 0;
      full_rejects    = 0;
      edge_ignores    = 0;
      dumped_chars    = 0;
      left_n          = 0;
      right_n         = 0;
   end

   function automatic line_result_type edit_result(input logic [KIND_W-1:0] k);
      line_result_type r;
      r.kind    = k;
      r.ch      = '0;
      r.is_last = 1'b1;
      r.length  = LEN_W'(left_n + right_n);
      r.cursor  = LEN_W'(left_n);
      return r;
   endfunction

   // Appends one expected result at the tail of the queue.
   task automatic queue_result(input line_result_type r);
      due_results = {due_results, r};
   endtask

   // Updates the editor state for one command and queues the results it causes.
   task automatic apply_command(input logic [CMD_W-1:0] c, input logic [CHAR_W-1:0] ch);
      line_result_type   r;
      logic [KIND_W-1:0] k;
      int unsigned       total;
      int unsigned       n;
      k = KIND_DONE;
      if (c == CMD_DUMP) begin
         total = left_n + right_n;
         if (total == 0) begin
            r = '0;
            r.kind    = KIND_EMPTY;
            r.is_last = 1'b1;
            queue_result(r);
         end else begin
            n = 0;
            for (int i = 0; i < DEPTH; i++) begin
               if (i < left_n || i >= DEPTH - right_n) begin
                  r = '0;
                  r.kind    = KIND_CHAR;
                  r.ch      = text_mem[i];
                  r.is_last = (n + 1 == total);
                  queue_result(r);
                  n++;
               end
            end
         end
         left_n  = 0;
         right_n = 0;
         return;
      end
      case (c)
         CMD_INSERT: begin
            if (left_n + right_n >= DEPTH) begin
               k = KIND_FULL;
            end else begin
               text_mem[left_n] = ch;
               left_n++;
            end
         end
         CMD_DELETE: begin
            if (left_n == 0) k = KIND_IGNORED;
            else left_n--;
         end
         CMD_RIGHT: begin
            if (right_n == 0) begin
               k = KIND_IGNORED;
            end else begin
               text_mem[left_n] = text_mem[DEPTH - right_n];
               left_n++;
               right_n--;
            end
         end
         CMD_LEFT: begin
            if (left_n == 0) begin
               k = KIND_IGNORED;
            end else begin
               right_n++;
               text_mem[DEPTH - right_n] = text_mem[left_n - 1];
               left_n--;
            end
         end
         default: k = KIND_IGNORED;
      endcase
      queue_result(edit_result(k));
   endtask

   always @(posedge clock) begin
      line_result_type got;
      line_result_type want;
      if (reset) begin
         left_n  = 0;
         right_n = 0;
         due_results.delete();
      end else begin
         // Results are taken first: a result never belongs to a command
         // accepted at the same edge.
         if (rsp_valid && !rsp_stall) begin
            got.kind    = rsp_kind;
            got.ch      = rsp_char_out;
            got.is_last = rsp_last;
            got.length  = rsp_text_length;
            got.cursor  = rsp_cursor_pos;
            results_seen++;
            if (due_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected result: kind %0d char %02h last %0b len %0d cursor %0d",
                           got.kind, got.ch, got.is_last, got.length, got.cursor);
            end else begin
               want = due_results.pop_front();
               if (got.kind == KIND_FULL) full_rejects++;
               if (got.kind == KIND_IGNORED) edge_ignores++;
               if (got.kind == KIND_CHAR) dumped_chars++;
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("Mismatch on result %0d:", results_seen);
                     $display("   expected kind %0d char %02h last %0b len %0d cursor %0d",
                              want.kind, want.ch, want.is_last, want.length, want.cursor);
                     $display("   actual   kind %0d char %02h last %0b len %0d cursor %0d",
                              got.kind, got.ch, got.is_last, got.length, got.cursor);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            commands_seen++;
            apply_command(req_cmd, req_char_in);
         end
      end
      pending_results <= due_results.size();
   end

endmodule

`default_nettype wire

// ===== test/cursor_text_gap_buffer_tb.sv =====
`default_nettype none

module cursor_text_gap_buffer_tb;
   import ctgb_pkg::*;

   localparam int DEPTH        = DEPTH_DEFAULT;
   localparam int HOLD_CYCLES  = 300;
   localparam int LIMIT_CYCLES = 400000;
   localparam int PHASE_ITEMS  = 65;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   logic [CMD_W-1:0]  req_cmd     = CMD_INSERT;
   logic [CHAR_W-1:0] req_char_in = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   logic [KIND_W-1:0] rsp_kind;
   logic [CHAR_W-1:0] rsp_char_out;
   logic              rsp_last;
   logic [LEN_W-1:0]  rsp_text_length;
   logic [LEN_W-1:0]  rsp_cursor_pos;

   int mismatches;
   int pending_results;
   int commands_seen;
   int results_seen;
   int full_rejects;
   int edge_ignores;
   int dumped_chars;

   int items_sent    = 0;
   int idle_pct      = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int cycle_count   = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   cursor_text_gap_buffer #(.DEPTH(DEPTH)) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_char_in     (req_char_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_char_out    (rsp_char_out),
      .rsp_last        (rsp_last),
      .rsp_text_length (rsp_text_length),
      .rsp_cursor_pos  (rsp_cursor_pos)
   );

   line_edit_checker #(.DEPTH(DEPTH)) checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_char_in     (req_char_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_char_out    (rsp_char_out),
      .rsp_last        (rsp_last),
      .rsp_text_length (rsp_text_length),
      .rsp_cursor_pos  (rsp_cursor_pos),
      .mismatches      (mismatches),
      .pending_results (pending_results),
      .commands_seen   (commands_seen),
      .results_seen    (results_seen),
      .full_rejects    (full_rejects),
      .edge_ignores    (edge_ignores),
      .dumped_chars    (dumped_chars)
   );

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (holds_served != hold_requests) begin
         hold_left    = HOLD_CYCLES;
         holds_served = holds_served + 1;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_results);
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_command(input logic [CMD_W-1:0] c, input logic [CHAR_W-1:0] ch);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid   <= 1'b0;
         req_cmd     <= CMD_W'($urandom);
         req_char_in <= CHAR_W'($urandom);
         @(posedge clock);
         while ($urandom_range(0, 99) < idle_pct) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= c;
      req_char_in <= ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // Lowers valid at the acceptance edge, then waits for every result.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   // Fills the store past its limit, edits the full text, then dumps it.
   task automatic fill_session();
      int moves;
      for (int i = 0; i < DEPTH + 2; i++) send_command(CMD_INSERT, CHAR_W'($urandom));
      moves = $urandom_range(1, 10);
      for (int i = 0; i < moves; i++) send_command(CMD_LEFT, '0);
      send_command(CMD_INSERT, CHAR_W'($urandom));
      send_command(CMD_RIGHT, '0);
      send_command(CMD_DELETE, '0);
      send_command(CMD_INSERT, CHAR_W'($urandom));
      send_command(CMD_INSERT, CHAR_W'($urandom));
      send_command(CMD_DUMP, '0);
   endtask

   initial begin
      int goal;
      int len;
      int pick;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Edges of an empty buffer, the unused codes and character extremes.
      send_command(CMD_DUMP, '0);
      send_command(CMD_DELETE, '0);
      send_command(CMD_LEFT, '0);
      send_command(CMD_RIGHT, '0);
      send_command(3'd5, 8'hFF);
      send_command(3'd6, 8'h00);
      send_command(3'd7, 8'hAA);
      send_command(CMD_INSERT, 8'h00);
      send_command(CMD_INSERT, 8'hFF);
      send_command(CMD_INSERT, 8'hA5);
      send_command(CMD_INSERT, 8'h5A);
      send_command(CMD_LEFT, '0);
      send_command(CMD_LEFT, '0);
      send_command(CMD_RIGHT, '0);
      send_command(CMD_INSERT, 8'h3C);
      send_command(CMD_DELETE, '0);
      for (int i = 0; i < 4; i++) send_command(CMD_LEFT, '0);
      send_command(CMD_DELETE, '0);
      for (int i = 0; i < 5; i++) send_command(CMD_RIGHT, '0);
      send_command(CMD_DUMP, '0);
      send_command(CMD_INSERT, 8'h7E);
      send_command(CMD_DUMP, '0);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 55; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 55; end
            default: begin idle_pct = 6; stall_pct <= 6; end
         endcase
         if (phase == 0) begin
            // The receiver holds off while a full store is offered, so the
            // block backs up; then the sender pauses until all results are in.
            hold_requests <= hold_requests + 1;
            fill_session();
            wait_drained();
         end
         if (phase == 2) fill_session();
         goal = items_sent + PHASE_ITEMS;
         while (items_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
               fill_session();
            end else if (pick < 22) begin
               len = $urandom_range(1, 6);
               for (int i = 0; i < len; i++)
                  send_command(CMD_W'($urandom), CHAR_W'($urandom));
            end else begin
               len = $urandom_range(3, 25);
               for (int i = 0; i < len; i++) begin
                  pick = $urandom_range(0, 99);
                  if (pick < 45) send_command(CMD_INSERT, CHAR_W'($urandom));
                  else if (pick < 60) send_command(CMD_DELETE, '0);
                  else if (pick < 75) send_command(CMD_LEFT, '0);
                  else if (pick < 90) send_command(CMD_RIGHT, '0);
                  else if (pick < 94) send_command(CMD_W'($urandom_range(5, 7)), CHAR_W'($urandom));
                  else send_command(CMD_INSERT, $urandom_range(0, 1) ? 8'hFF : 8'h00);
               end
               send_command(CMD_DUMP, '0);
            end
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      $display("Ran %0d commands through four idle and stall mixes, %0d results checked.",
               commands_seen, results_seen);
      $display("Covered %0d full-store rejects, %0d ignored commands, %0d dumped characters.",
               full_rejects, edge_ignores, dumped_chars);
      if (mismatches == 0 && pending_results == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
